@@ hdl/obm_pkg.sv @@
`default_nettype none
package obm_pkg;

  // right shift applied to a full product before capping
  typedef enum logic [1:0] {
    SH0  = 2'd0,
    SH24 = 2'd1,
    SH30 = 2'd2,
    SH45 = 2'd3
  } shift_t;

  localparam int MODE_LIMIT = 2;

  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;

  // atan(2^-k) in 2^-32 turn units
  localparam logic [29:0] ATAN_TURNS [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

endpackage
`default_nettype wire

@@ hdl/obm_mul.sv @@
`default_nettype none
// Sign-magnitude 64x64 multiplier built on one 32x32 multiplier, four
// partial products over successive cycles. Result is shifted, truncated
// toward zero and capped at 2^61 in magnitude. raw gives the low product bits.
module obm_mul
  import obm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  shift_t             sh,
  output logic               done,
  output logic signed [63:0] res,
  output logic [63:0]        raw
);

  localparam logic [127:0] PROD_CAP = 128'd1 << 61;

  logic [63:0]  ua;
  logic [63:0]  ub;
  logic         neg;
  shift_t       sh_r;
  logic [127:0] acc;
  logic [63:0]  pp;
  logic [1:0]   pp_off;
  logic         pp_vld;
  logic [2:0]   step;
  logic         busy;

  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [127:0] pp_wide;
  logic [127:0] shf;
  logic [61:0]  mag;

  assign a_half = step[1] ? ua[63:32] : ua[31:0];
  assign b_half = step[0] ? ub[63:32] : ub[31:0];

  always_comb begin
    unique case (pp_off)
      2'd0:    pp_wide = {64'd0, pp};
      2'd1:    pp_wide = {32'd0, pp, 32'd0};
      default: pp_wide = {pp, 64'd0};
    endcase
  end

  always_comb begin
    unique case (sh_r)
      SH0:  shf = acc;
      SH24: shf = acc >> 24;
      SH30: shf = acc >> 30;
      SH45: shf = acc >> 45;
    endcase
    mag = (shf > PROD_CAP) ? PROD_CAP[61:0] : shf[61:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      step   <= 3'd0;
      pp_vld <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy   <= 1'b1;
        step   <= 3'd0;
        pp_vld <= 1'b0;
      end else if (busy) begin
        step   <= step + 3'd1;
        pp_vld <= ~step[2];
        if (step == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ua   <= a[63] ? 64'(-a) : 64'(a);
      ub   <= b[63] ? 64'(-b) : 64'(b);
      neg  <= a[63] ^ b[63];
      sh_r <= sh;
      acc  <= '0;
    end else if (busy) begin
      if (!step[2]) begin
        pp     <= a_half * b_half;
        pp_off <= {1'b0, step[1]} + {1'b0, step[0]};
      end
      if (pp_vld) acc <= acc + pp_wide;
      if (step == 3'd5) begin
        res <= neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        raw <= acc[63:0];
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/oscillator_bank_observer_unit.sv @@
`default_nettype none
// Harmonic oscillator bank observer, up to two modes plus an offset.
// Input stream s_*: tuser = opcode (0 measurement, 1 prediction); tdata holds
// time_ticks, sample_value, horizon_ticks. Each input beat yields exactly one
// output beat on m_*: tuser = status, tdata = result_value.
// Config port cfg_*: index 0..7 selects mode_count, the two frequencies and
// the five gains; always ready, write only while no item is in flight.
// One item at a time: s_tready is high only while the sequencer is idle.
// A rotated mode takes eight trips through the shared multiplier, the CORDIC
// loop (one step per cycle) and a 45-step restoring divider for sin/w. A
// measurement adds two gain multiplies per mode plus one for the offset.
// Dropped and unstarted items go straight to the response.
// The result sits in an output register; the next item is accepted while it
// waits, but a new result holds the sequencer until m_tready takes the old one.
// Synchronous reset clears config, state and the output valid.
module oscillator_bank_observer_unit
  import obm_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,   // time_ticks[47:0], sample_value, horizon_ticks
  input  logic [0:0]   s_tuser,   // opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // result_value
  output logic [1:0]   m_tuser    // status
);

  localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [SW-1:0] CORD_LAST = SW'(CORDIC_STEPS - 1);
  localparam logic [5:0] DIV_LAST = 6'd44;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DROP    = 2'd1;
  localparam logic [1:0] ST_NOSTART = 2'd2;
  localparam logic [1:0] ST_PRED    = 2'd3;

  typedef enum logic [2:0] {
    R_MODE_COUNT  = 3'd0,
    R_FREQ_A      = 3'd1,
    R_FREQ_B      = 3'd2,
    R_GAIN_POS_A  = 3'd3,
    R_GAIN_VEL_A  = 3'd4,
    R_GAIN_POS_B  = 3'd5,
    R_GAIN_VEL_B  = 3'd6,
    R_GAIN_OFFSET = 3'd7
  } cfg_reg_t;

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_LOAD  = 17'h00002,
    S_PHASE = 17'h00004,
    S_CORD  = 17'h00008,
    S_DVSR  = 17'h00010,
    S_DIV   = 17'h00020,
    S_SF    = 17'h00040,
    S_WS    = 17'h00080,
    S_CP    = 17'h00100,
    S_SV    = 17'h00200,
    S_CV    = 17'h00400,
    S_WP    = 17'h00800,
    S_GPOS  = 17'h01000,
    S_GVEL  = 17'h02000,
    S_ACC   = 17'h04000,
    S_GOFS  = 17'h08000,
    S_RESP  = 17'h10000
  } state_t;

  localparam logic [16:0] MUL_STATES = S_PHASE | S_DVSR | S_SF | S_WS | S_CP | S_SV |
                                       S_CV | S_WP | S_GPOS | S_GVEL | S_GOFS;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sd140737488355327) return 48'sh7FFF_FFFF_FFFF;
    else if (v < -64'sd140737488355328) return 48'sh8000_0000_0000;
    else return v[47:0];
  endfunction

  // config
  logic [1:0]         mode_count;
  logic [23:0]        freq [2];
  logic signed [31:0] gain_pos [2];
  logic signed [31:0] gain_vel [2];
  logic signed [31:0] gain_ofs;

  // observer state
  logic               started;
  logic [47:0]        last_time;
  logic signed [47:0] pos [2];
  logic signed [47:0] vel [2];
  logic signed [47:0] offset;

  // working registers
  state_t             state;
  state_t             state_next;
  logic               op_r;
  logic [47:0]        t_r;
  logic [47:0]        ticks;
  logic signed [51:0] innov;
  logic               m;
  logic signed [47:0] wp;
  logic signed [47:0] wv;
  logic signed [35:0] x;
  logic signed [35:0] y;
  logic signed [35:0] z;
  logic               flip;
  logic [SW-1:0]      cord_cnt;
  logic signed [35:0] c_r;
  logic signed [35:0] s_r;
  logic [55:0]        dvs;
  logic [56:0]        rem;
  logic [44:0]        quo;
  logic [5:0]         div_cnt;
  logic signed [46:0] sw_r;
  logic signed [63:0] ws_r;
  logic signed [63:0] t1;
  logic signed [47:0] np_r;
  logic signed [49:0] sum;
  logic [1:0]         status_r;

  // multiplier
  logic               mul_go;
  logic signed [63:0] mul_a;
  logic signed [63:0] mul_b;
  shift_t             mul_sh;
  logic               mul_done;
  logic signed [63:0] mul_res;
  logic [63:0]        mul_raw;

  obm_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .sh   (mul_sh),
    .done (mul_done),
    .res  (mul_res),
    .raw  (mul_raw)
  );

  // input fields
  logic               in_fire;
  logic               in_op;
  logic [47:0]        in_time;
  logic signed [31:0] in_sample;
  logic [31:0]        in_hor;

  assign s_tready  = (state == S_IDLE);
  assign in_fire   = s_tvalid & s_tready;
  assign in_op     = s_tuser[0];
  assign in_time   = s_tdata[47:0];
  assign in_sample = $signed(s_tdata[79:48]);
  assign in_hor    = s_tdata[111:80];
  assign cfg_ready = 1'b1;

  logic [1:0]         n_act;
  logic               act0;
  logic               act1;
  logic               act_m;
  logic [23:0]        freq_m;
  logic signed [51:0] innov_calc;
  logic               out_free;
  state_t             fin_state;

  assign n_act    = (mode_count > 2'(MODE_LIMIT)) ? 2'(MODE_LIMIT) : mode_count;
  assign act0     = (n_act > 2'd0);
  assign act1     = (n_act > 2'd1);
  assign act_m    = m ? act1 : act0;
  assign freq_m   = freq[m];
  assign out_free = ~m_tvalid | m_tready;
  assign fin_state = op_r ? S_RESP : S_GOFS;

  // innovation against the state before propagation
  assign innov_calc = (52'(in_sample) <<< 8) - 52'(offset)
                      - (act0 ? 52'(pos[0]) : 52'sd0)
                      - (act1 ? 52'(pos[1]) : 52'sd0);

  // CORDIC step
  logic [4:0]         k;
  logic signed [35:0] atan_k;
  logic signed [35:0] x_n;
  logic signed [35:0] y_n;
  logic signed [35:0] z_n;
  logic [31:0]        ph;
  logic [31:0]        ph_q;
  logic [31:0]        ph2;

  assign k      = 5'(cord_cnt);
  assign atan_k = $signed({6'd0, ATAN_TURNS[k]});
  assign ph     = mul_raw[31:0];
  assign ph_q   = ph + 32'h4000_0000;
  assign ph2    = ph_q[31] ? ph + 32'h8000_0000 : ph;

  always_comb begin
    if (!z[35]) begin
      x_n = x - (y >>> k);
      y_n = y + (x >>> k);
      z_n = z - atan_k;
    end else begin
      x_n = x + (y >>> k);
      y_n = y - (x >>> k);
      z_n = z + atan_k;
    end
  end

  // divider step: one quotient bit per cycle
  logic [56:0]        r2;
  logic               ge;
  logic [56:0]        rem_n;
  logic [44:0]        quo_n;
  logic [35:0]        abs_s;

  assign r2    = {rem[55:0], 1'b0};
  assign ge    = (r2 >= {1'b0, dvs});
  assign rem_n = ge ? r2 - {1'b0, dvs} : r2;
  assign quo_n = {quo[43:0], ge};
  assign abs_s = s_r[35] ? 36'(-s_r) : 36'(s_r);

  // prediction output
  logic signed [41:0] sum_q16;
  logic [31:0]        pred_val;

  assign sum_q16 = 42'(sum >>> 8);
  always_comb begin
    if (sum_q16 > 42'sd2147483647) pred_val = 32'h7FFF_FFFF;
    else if (sum_q16 < -42'sd2147483648) pred_val = 32'h8000_0000;
    else pred_val = sum_q16[31:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_op) state_next = started ? S_LOAD : S_RESP;
          else if (!started || in_time <= last_time) state_next = S_RESP;
          else state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!act_m) state_next = fin_state;
        else if (freq_m == 24'd0) state_next = op_r ? S_ACC : S_GPOS;
        else state_next = S_PHASE;
      end
      S_PHASE: if (mul_done) state_next = S_CORD;
      S_CORD:  if (cord_cnt == CORD_LAST) state_next = S_DVSR;
      S_DVSR:  if (mul_done) state_next = S_DIV;
      S_DIV:   if (div_cnt == DIV_LAST) state_next = S_SF;
      S_SF:    if (mul_done) state_next = S_WS;
      S_WS:    if (mul_done) state_next = S_CP;
      S_CP:    if (mul_done) state_next = S_SV;
      S_SV:    if (mul_done) state_next = S_CV;
      S_CV:    if (mul_done) state_next = S_WP;
      S_WP:    if (mul_done) state_next = op_r ? S_ACC : S_GPOS;
      S_GPOS:  if (mul_done) state_next = S_GVEL;
      S_GVEL:  if (mul_done) state_next = m ? fin_state : S_LOAD;
      S_ACC:   state_next = m ? fin_state : S_LOAD;
      S_GOFS:  if (mul_done) state_next = S_RESP;
      S_RESP:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // operands are latched by the multiplier on the cycle a mul state is entered
  assign mul_go = (state_next != state) && ((state_next & MUL_STATES) != 17'd0);

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_sh = SH0;
    unique case (state_next)
      S_PHASE: begin
        mul_a = {40'd0, freq_m};
        mul_b = {32'd0, ticks[31:0]};
      end
      S_DVSR: begin
        mul_a = {40'd0, freq_m};
        mul_b = {32'd0, TWO_PI_Q29};
      end
      S_SF: begin
        mul_a = 64'(s_r);
        mul_b = {40'd0, freq_m};
      end
      S_WS: begin
        mul_a  = mul_res;
        mul_b  = {32'd0, TWO_PI_Q29};
        mul_sh = SH45;
      end
      S_CP: begin
        mul_a  = 64'(c_r);
        mul_b  = 64'(wp);
        mul_sh = SH30;
      end
      S_SV: begin
        mul_a  = 64'(sw_r);
        mul_b  = 64'(wv);
        mul_sh = SH30;
      end
      S_CV: begin
        mul_a  = 64'(c_r);
        mul_b  = 64'(wv);
        mul_sh = SH30;
      end
      S_WP: begin
        mul_a  = ws_r;
        mul_b  = 64'(wp);
        mul_sh = SH30;
      end
      S_GPOS: begin
        mul_a  = 64'(gain_pos[m]);
        mul_b  = 64'(innov);
        mul_sh = SH24;
      end
      S_GVEL: begin
        mul_a  = 64'(gain_vel[m]);
        mul_b  = 64'(innov);
        mul_sh = SH24;
      end
      S_GOFS: begin
        mul_a  = 64'(gain_ofs);
        mul_b  = 64'(innov);
        mul_sh = SH24;
      end
      default: begin
        mul_a  = '0;
        mul_b  = '0;
        mul_sh = SH0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_count  <= 2'd0;
      freq[0]     <= '0;
      freq[1]     <= '0;
      gain_pos[0] <= '0;
      gain_pos[1] <= '0;
      gain_vel[0] <= '0;
      gain_vel[1] <= '0;
      gain_ofs    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        R_MODE_COUNT:  mode_count  <= cfg_data[1:0];
        R_FREQ_A:      freq[0]     <= cfg_data[23:0];
        R_FREQ_B:      freq[1]     <= cfg_data[23:0];
        R_GAIN_POS_A:  gain_pos[0] <= $signed(cfg_data);
        R_GAIN_VEL_A:  gain_vel[0] <= $signed(cfg_data);
        R_GAIN_POS_B:  gain_pos[1] <= $signed(cfg_data);
        R_GAIN_VEL_B:  gain_vel[1] <= $signed(cfg_data);
        R_GAIN_OFFSET: gain_ofs    <= $signed(cfg_data);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      started   <= 1'b0;
      last_time <= '0;
      pos[0]    <= '0;
      pos[1]    <= '0;
      vel[0]    <= '0;
      vel[1]    <= '0;
      offset    <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;

      // a new beat replaces the old one in the same cycle it is taken
      if (state == S_RESP && out_free) begin
        m_tvalid <= 1'b1;
        m_tuser  <= status_r;
        m_tdata  <= (status_r == ST_PRED) ? pred_val : 32'd0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            op_r <= in_op;
            t_r  <= in_time;
            m    <= 1'b0;
            if (in_op) begin
              status_r <= started ? ST_PRED : ST_NOSTART;
              sum      <= 50'(offset);
              ticks    <= {16'd0, in_hor};
            end else if (!started) begin
              // first sample seeds the offset and clears the modes
              pos[0]    <= '0;
              pos[1]    <= '0;
              vel[0]    <= '0;
              vel[1]    <= '0;
              offset    <= 48'(in_sample) <<< 8;
              last_time <= in_time;
              started   <= 1'b1;
              status_r  <= ST_OK;
            end else if (in_time <= last_time) begin
              status_r <= ST_DROP;
            end else begin
              status_r <= ST_OK;
              ticks    <= in_time - last_time;
              innov    <= innov_calc;
            end
          end
        end
        S_LOAD: begin
          wp <= pos[m];
          wv <= vel[m];
        end
        S_PHASE: begin
          if (mul_done) begin
            // fold angles outside +-90 degrees by a half turn
            flip     <= ph_q[31];
            z        <= 36'($signed(ph2));
            x        <= $signed({6'd0, CORDIC_GAIN_Q30});
            y        <= '0;
            cord_cnt <= '0;
          end
        end
        S_CORD: begin
          x        <= x_n;
          y        <= y_n;
          z        <= z_n;
          cord_cnt <= cord_cnt + SW'(1);
          if (cord_cnt == CORD_LAST) begin
            c_r <= flip ? -x_n : x_n;
            s_r <= flip ? -y_n : y_n;
          end
        end
        S_DVSR: begin
          if (mul_done) begin
            dvs     <= mul_raw[55:0];
            rem     <= 57'(abs_s);
            quo     <= '0;
            div_cnt <= '0;
          end
        end
        S_DIV: begin
          rem     <= rem_n;
          quo     <= quo_n;
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == DIV_LAST) begin
            sw_r <= s_r[35] ? -$signed({2'b00, quo_n}) : $signed({2'b00, quo_n});
          end
        end
        S_WS: if (mul_done) ws_r <= mul_res;
        S_CP: if (mul_done) t1 <= mul_res;
        S_SV: if (mul_done) np_r <= sat48(t1 + mul_res);
        S_CV: if (mul_done) t1 <= mul_res;
        S_WP: begin
          if (mul_done) begin
            wp <= np_r;
            wv <= sat48(t1 - mul_res);
          end
        end
        S_GPOS: if (mul_done) pos[m] <= sat48(64'(wp) + mul_res);
        S_GVEL: begin
          if (mul_done) begin
            vel[m] <= sat48(64'(wv) + mul_res);
            m      <= 1'b1;
          end
        end
        S_ACC: begin
          sum <= sum + 50'(wp);
          m   <= 1'b1;
        end
        S_GOFS: begin
          if (mul_done) begin
            offset    <= sat48(64'(offset) + mul_res);
            last_time <= t_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import obm_pkg::*;

  localparam int CORDIC_STEPS = 24;
  localparam longint RUN_LIMIT = 3000000;

  localparam bit OP_MEASURE = 1'b0;
  localparam bit OP_PREDICT = 1'b1;

  localparam bit [1:0] ST_ACCEPTED    = 2'd0;
  localparam bit [1:0] ST_DROPPED     = 2'd1;
  localparam bit [1:0] ST_NOT_STARTED = 2'd2;
  localparam bit [1:0] ST_PREDICTED   = 2'd3;

  localparam bit [2:0] REG_MODE_COUNT  = 3'd0;
  localparam bit [2:0] REG_FREQ_A      = 3'd1;
  localparam bit [2:0] REG_FREQ_B      = 3'd2;
  localparam bit [2:0] REG_GAIN_POS_A  = 3'd3;
  localparam bit [2:0] REG_GAIN_VEL_A  = 3'd4;
  localparam bit [2:0] REG_GAIN_POS_B  = 3'd5;
  localparam bit [2:0] REG_GAIN_VEL_B  = 3'd6;
  localparam bit [2:0] REG_GAIN_OFFSET = 3'd7;

  localparam longint PRODUCT_CAP = 64'sd1 <<< 61;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [111:0] s_tdata;   // time_ticks[47:0], sample_value, horizon_ticks
  logic [0:0]   s_tuser;   // opcode
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;   // result_value
  logic [1:0]   m_tuser;   // status

  oscillator_bank_observer_unit #(.CORDIC_STEPS(CORDIC_STEPS)) uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  typedef struct {
    bit [1:0]  status;
    bit [31:0] value;
  } obs_result_t;

  typedef struct {
    bit        op;
    bit [47:0] ticks;
    bit [31:0] sample;
    bit [31:0] horizon;
    bit        typed;
    bit [1:0]  status;
    bit [31:0] value;
  } stim_row_t;

  obs_result_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint cycles = 0;

  // shadow copy of configuration and observer state
  bit [1:0]  cfg_modes;
  bit [23:0] cfg_freq[2];
  bit [31:0] cfg_gain_pos[2];
  bit [31:0] cfg_gain_vel[2];
  bit [31:0] cfg_gain_off;
  bit        obs_started;
  bit [47:0] obs_last_time;
  longint    obs_pos[2];
  longint    obs_vel[2];
  longint    obs_offset;

  function automatic longint clamp48(longint v);
    longint hi;
    hi = (64'sd1 <<< 47) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // exact product shifted right, truncated toward zero, magnitude capped
  function automatic longint mul_trunc(longint a, longint b, int sh);
    bit neg;
    logic [127:0] ua, ub, p;
    longint m;
    neg = (a < 0) != (b < 0);
    ua = {64'd0, (a < 0) ? 64'(-a) : 64'(a)};
    ub = {64'd0, (b < 0) ? 64'(-b) : 64'(b)};
    p = (ua * ub) >> sh;
    if (p > 128'(PRODUCT_CAP)) p = 128'(PRODUCT_CAP);
    m = longint'(p[63:0]);
    return neg ? -m : m;
  endfunction

  task automatic cordic_sincos(input bit [31:0] ph, output longint c, output longint s);
    bit flip;
    bit [31:0] p2;
    bit [31:0] q;
    longint z, x, y, dx, dy;
    int k;
    q = ph + 32'h4000_0000;
    flip = q[31];
    p2 = flip ? ph + 32'h8000_0000 : ph;
    z = longint'(signed'(p2));
    x = longint'({34'd0, CORDIC_GAIN_Q30});
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      k = i & 31;
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'({34'd0, ATAN_TURNS[k]});
      end else begin
        x += dx; y -= dy; z += longint'({34'd0, ATAN_TURNS[k]});
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic rotate_mode(input bit [23:0] freq, input bit [47:0] ticks,
                             inout longint p, inout longint v);
    longint c, s, sw, ws, np, nv, two_pi;
    bit [63:0] prod, d;
    logic [127:0] quo;
    if (freq == 0) return;
    prod = 64'(freq) * 64'(ticks);
    cordic_sincos(prod[31:0], c, s);
    two_pi = longint'({32'd0, TWO_PI_Q29});
    d = 64'(freq) * 64'(TWO_PI_Q29);
    quo = ({64'd0, (s < 0) ? 64'(-s) : 64'(s)} << 45) / {64'd0, d};
    sw = (s < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    ws = mul_trunc(s * longint'({40'd0, freq}), two_pi, 45);
    np = clamp48(mul_trunc(c, p, 30) + mul_trunc(sw, v, 30));
    nv = clamp48(mul_trunc(c, v, 30) - mul_trunc(ws, p, 30));
    p = np;
    v = nv;
  endtask

  task automatic predict_observer(input bit op, input bit [47:0] ticks,
                                  input bit [31:0] sample, input bit [31:0] horizon,
                                  output obs_result_t res);
    int n;
    longint smp, sum, r, innov, p, v;
    n = (cfg_modes > 2) ? 2 : cfg_modes;
    smp = longint'(signed'(sample)) * 256;
    res.status = ST_ACCEPTED;
    res.value = '0;
    if (op == OP_PREDICT) begin
      if (!obs_started) begin
        res.status = ST_NOT_STARTED;
        return;
      end
      sum = obs_offset;
      for (int i = 0; i < n; i++) begin
        p = obs_pos[i];
        v = obs_vel[i];
        rotate_mode(cfg_freq[i], {16'd0, horizon}, p, v);
        sum += p;
      end
      r = sum >>> 8;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      res.status = ST_PREDICTED;
      res.value = r[31:0];
      return;
    end
    if (!obs_started) begin
      for (int i = 0; i < 2; i++) begin
        obs_pos[i] = 0;
        obs_vel[i] = 0;
      end
      obs_offset = smp;
      obs_last_time = ticks;
      obs_started = 1;
      return;
    end
    if (ticks <= obs_last_time) begin
      res.status = ST_DROPPED;
      return;
    end
    innov = smp - obs_offset;
    for (int i = 0; i < n; i++) innov -= obs_pos[i];
    for (int i = 0; i < n; i++) begin
      rotate_mode(cfg_freq[i], ticks - obs_last_time, obs_pos[i], obs_vel[i]);
      obs_pos[i] = clamp48(obs_pos[i] +
                           mul_trunc(longint'(signed'(cfg_gain_pos[i])), innov, 24));
      obs_vel[i] = clamp48(obs_vel[i] +
                           mul_trunc(longint'(signed'(cfg_gain_vel[i])), innov, 24));
    end
    obs_offset = clamp48(obs_offset + mul_trunc(longint'(signed'(cfg_gain_off)), innov, 24));
    obs_last_time = ticks;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // back-to-back register writes keep cfg_valid high; caller lowers it
  task automatic write_reg(bit [2:0] idx, bit [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE_COUNT:  cfg_modes = data[1:0];
      REG_FREQ_A:      cfg_freq[0] = data[23:0];
      REG_FREQ_B:      cfg_freq[1] = data[23:0];
      REG_GAIN_POS_A:  cfg_gain_pos[0] = data;
      REG_GAIN_VEL_A:  cfg_gain_vel[0] = data;
      REG_GAIN_POS_B:  cfg_gain_pos[1] = data;
      REG_GAIN_VEL_B:  cfg_gain_vel[1] = data;
      REG_GAIN_OFFSET: cfg_gain_off = data;
      default: ;
    endcase
  endtask

  task automatic program_regs(bit [1:0] modes, bit [23:0] fa, bit [23:0] fb,
                              bit [31:0] gpa, bit [31:0] gva, bit [31:0] gpb,
                              bit [31:0] gvb, bit [31:0] goff);
    write_reg(REG_MODE_COUNT, {30'd0, modes});
    write_reg(REG_FREQ_A, {8'd0, fa});
    write_reg(REG_FREQ_B, {8'd0, fb});
    write_reg(REG_GAIN_POS_A, gpa);
    write_reg(REG_GAIN_VEL_A, gva);
    write_reg(REG_GAIN_POS_B, gpb);
    write_reg(REG_GAIN_VEL_B, gvb);
    write_reg(REG_GAIN_OFFSET, goff);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(bit op, bit [47:0] ticks, bit [31:0] sample,
                           bit [31:0] horizon, bit typed, bit [1:0] st, bit [31:0] val);
    obs_result_t res;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {horizon, sample, ticks};
    do @(posedge clk); while (!s_tready);
    predict_observer(op, ticks, sample, horizon, res);
    if (typed) begin
      res.status = st;
      res.value = val;
    end
    pending_results.insert(pending_results.size(), res);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain;
    @(posedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_random_item;
    int r;
    bit [47:0] t, dt;
    bit [31:0] smp, hz;
    r = $urandom_range(99);
    hz = $urandom;
    smp = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(0, 2097152)) - 32'd1048576;
    if (r < 60) begin
      dt = ($urandom_range(99) < 80) ? 48'($urandom_range(1, 8192))
                                     : 48'($urandom_range(1, 16777216));
      t = obs_last_time + dt;
      if (t <= obs_last_time) t = 48'(obs_last_time - dt);
      send_item(OP_MEASURE, t, smp, hz, 0, ST_ACCEPTED, '0);
    end else if (r < 85) begin
      if ($urandom_range(99) < 70) hz = $urandom_range(0, 1048576);
      send_item(OP_PREDICT, 48'({$urandom, $urandom}), $urandom, hz, 0, ST_ACCEPTED, '0);
    end else if (r < 95) begin
      t = 48'({$urandom, $urandom});
      t = t % (obs_last_time + 48'd1);
      send_item(OP_MEASURE, t, $urandom, hz, 0, ST_ACCEPTED, '0);
    end else begin
      t = obs_last_time + 48'($urandom_range(1, 1073741823));
      send_item(OP_MEASURE, t, smp, hz, 0, ST_ACCEPTED, '0);
    end
  endtask

  stim_row_t directed[] = '{
    '{OP_PREDICT, 48'd5, 32'h1234_5678, 32'd100, 1, ST_NOT_STARTED, 32'd0},
    '{OP_MEASURE, 48'd100, 32'h8000_0000, 32'hFFFF_FFFF, 1, ST_ACCEPTED, 32'd0},
    '{OP_MEASURE, 48'd100, 32'h0000_0001, 32'd0, 1, ST_DROPPED, 32'd0},
    '{OP_MEASURE, 48'd0, 32'h7FFF_FFFF, 32'd0, 1, ST_DROPPED, 32'd0},
    '{OP_PREDICT, 48'hFFFF_FFFF_FFFF, 32'd0, 32'd0, 1, ST_PREDICTED, 32'h8000_0000},
    '{OP_MEASURE, 48'd200, 32'h7FFF_FFFF, 32'd12, 0, ST_ACCEPTED, 32'd0},
    '{OP_PREDICT, 48'd0, 32'd0, 32'hFFFF_FFFF, 0, ST_ACCEPTED, 32'd0},
    '{OP_MEASURE, 48'h7FFF_0000_0000, 32'd0, 32'd0, 0, ST_ACCEPTED, 32'd0},
    '{OP_PREDICT, 48'd0, 32'd0, 32'd1, 0, ST_ACCEPTED, 32'd0},
    '{OP_MEASURE, 48'h7FFF_0001_0000, 32'd12345, 32'd0, 0, ST_ACCEPTED, 32'd0},
    '{OP_PREDICT, 48'd0, 32'd0, 32'd32768, 0, ST_ACCEPTED, 32'd0},
    '{OP_MEASURE, 48'h7FFF_0001_0001, 32'hFFFF_FFFF, 32'd0, 0, ST_ACCEPTED, 32'd0},
    '{OP_PREDICT, 48'd0, 32'd0, 32'd0, 0, ST_ACCEPTED, 32'd0}
  };

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random backpressure and in-order checking
  always @(posedge clk) begin
    obs_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected beat", m_tdata, 0);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (m_tuser !== want.status) report_mismatch("status", m_tuser, want.status);
          if (m_tdata !== want.value) report_mismatch("result_value", m_tdata, want.value);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_modes = 0;
    cfg_gain_off = 0;
    for (int i = 0; i < 2; i++) begin
      cfg_freq[i] = 0; cfg_gain_pos[i] = 0; cfg_gain_vel[i] = 0;
      obs_pos[i] = 0; obs_vel[i] = 0;
    end
    obs_started = 0;
    obs_last_time = 0;
    obs_offset = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    program_regs(2'd2, 24'd65536, 24'hFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h0040_0000, 32'hFFC0_0000, 32'h0080_0000);
    send_idle_pct = 18;
    recv_idle_pct = 86;
    foreach (directed[i])
      send_item(directed[i].op, directed[i].ticks, directed[i].sample, directed[i].horizon,
                directed[i].typed, directed[i].status, directed[i].value);
    drain();

    for (int seg = 0; seg < 6; seg++) begin
      send_idle_pct = (seg < 2) ? 18 : (seg < 4) ? 86 : 0;
      recv_idle_pct = (seg < 2) ? 86 : (seg < 4) ? 18 : 0;
      case (seg)
        0: program_regs(2'd3, 24'hFF_FFFF, 24'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        1: program_regs(2'd0, 24'd0, 24'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                        32'h0020_0000);
        default: program_regs(2'($urandom_range(1, 2)),
                              24'($urandom_range(1, 1310720)),
                              24'($urandom_range(1, 1310720)),
                              32'($urandom_range(0, 16777216)) - 32'd8388608,
                              32'($urandom_range(0, 16777216)) - 32'd8388608,
                              32'($urandom_range(0, 16777216)) - 32'd8388608,
                              32'($urandom_range(0, 16777216)) - 32'd8388608,
                              32'($urandom_range(0, 16777216)) - 32'd8388608);
      endcase
      repeat (175) send_random_item();
      if (seg == 5) begin
        send_item(OP_MEASURE, 48'hFFFF_FFFF_FFFF, 32'd77, 32'd0, 0, ST_ACCEPTED, '0);
        send_item(OP_MEASURE, 48'hFFFF_FFFF_FFFF, 32'd78, 32'd0, 1, ST_DROPPED, '0);
      end
      drain();
    end

    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/obm_pkg.sv
hdl/obm_mul.sv
hdl/oscillator_bank_observer_unit.sv
verif/tb_top.sv
